// ===== design/psg_tone_noise_envelope_assert.svh =====
// assertion macros shared by the sound generator
`ifndef PSG_TONE_NOISE_ENVELOPE_ASSERT_SVH
`define PSG_TONE_NOISE_ENVELOPE_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define PSG_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define PSG_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// shared types, codes and the volume table of the sound generator
// ----------------------------------------------------------------------------
package psg_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_LATCH = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    // register file indexes
    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_VOL_A     = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam int NUM_REGS  = 16;
    localparam int NUM_TONES = 3;

    localparam logic [3:0] VOL_MAX = 4'hf;
    localparam logic [3:0] VOL_MIN = 4'h0;

    typedef logic [7:0] t_reg_file [NUM_REGS];

    // envelope control from the top level
    typedef struct packed {
        logic tick;
        logic restart;
        logic attack_in;
        logic cont;
        logic alt;
        logic hold;
    } t_env_ctl;

    // logarithmic volume table
    function automatic logic [5:0] vol_table(input logic [3:0] v);
        logic [5:0] r;
        case (v)
            4'd0:    r = 6'd0;
            4'd1:    r = 6'd1;
            4'd2:    r = 6'd2;
            4'd3:    r = 6'd3;
            4'd4:    r = 6'd4;
            4'd5:    r = 6'd5;
            4'd6:    r = 6'd7;
            4'd7:    r = 6'd10;
            4'd8:    r = 6'd13;
            4'd9:    r = 6'd18;
            4'd10:   r = 6'd24;
            4'd11:   r = 6'd30;
            4'd12:   r = 6'd36;
            4'd13:   r = 6'd40;
            default: r = 6'd42;
        endcase
        return r;
    endfunction

endpackage

// ===== design/psg_if.sv =====
// ----------------------------------------------------------------------------
// psg_if
// valid/ready channels for items in and results out
// ----------------------------------------------------------------------------
interface psg_in_if;
    logic             valid;
    logic             ready;
    psg_pkg::t_op     operation;
    logic [7:0]       write_data;

    modport source (output valid, output operation, output write_data, input ready);
    modport sink   (input valid, input operation, input write_data, output ready);
endinterface

interface psg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [6:0] amplitude;

    modport source (output valid, output read_data, output amplitude, input ready);
    modport sink   (input valid, input read_data, input amplitude, output ready);
endinterface

// ===== design/psg_tone.sv =====
// ----------------------------------------------------------------------------
// psg_tone
// one square-wave tone channel: period counter and output level
// ----------------------------------------------------------------------------
module psg_tone (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick,
    input  logic [11:0] i_period,
    output logic        o_level_next
);

    logic [11:0] r_count, n_count;
    logic        r_level, n_level;
    logic [12:0] w_inc;
    logic [12:0] w_period;

    // zero period acts as one
    assign w_period = (i_period == 12'd0) ? 13'd1 : {1'b0, i_period};
    assign w_inc    = {1'b0, r_count} + 13'd1;

    // counter step and toggle
    always_comb begin
        n_count = r_count;
        n_level = r_level;
        if (i_tick) begin
            if (w_inc >= w_period) begin
                n_count = 12'd0;
                n_level = ~r_level;
            end else begin
                n_count = w_inc[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 12'd0;
            r_level <= 1'b0;
        end else begin
            r_count <= n_count;
            r_level <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule

// ===== design/psg_noise.sv =====
// ----------------------------------------------------------------------------
// psg_noise
// 17-bit noise shift register stepped every twice the noise period
// ----------------------------------------------------------------------------
module psg_noise (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic [4:0] i_period,
    output logic       o_level_next
);

    logic [5:0]  r_count, n_count;
    logic [16:0] r_shift, n_shift;
    logic        r_level, n_level;
    logic [6:0]  w_inc;
    logic [6:0]  w_limit;
    logic        w_fb;

    // limit is twice the period, zero acting as one
    assign w_limit = (i_period == 5'd0) ? 7'd2 : {1'b0, i_period, 1'b0};
    assign w_inc   = {1'b0, r_count} + 7'd1;
    assign w_fb    = r_shift[0] ^ r_shift[3];

    // counter and shift step
    always_comb begin
        n_count = r_count;
        n_shift = r_shift;
        n_level = r_level;
        if (i_tick) begin
            if (w_inc >= w_limit) begin
                n_count = 6'd0;
                n_shift = {w_fb, r_shift[16:1]};
                n_level = r_shift[1];
            end else begin
                n_count = w_inc[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 6'd0;
            r_shift <= 17'd1;
            r_level <= 1'b0;
        end else begin
            r_count <= n_count;
            r_shift <= n_shift;
            r_level <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule

// ===== design/psg_env.sv =====
// ----------------------------------------------------------------------------
// psg_env
// envelope generator: step counter, attack direction and volume
// ----------------------------------------------------------------------------
module psg_env (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psg_pkg::t_env_ctl i_ctl,
    input  logic [15:0]       i_period,
    output logic [3:0]        o_volume_next
);

    logic [20:0] r_count, n_count;
    logic [4:0]  r_step, n_step;
    logic        r_attack, n_attack;
    logic [3:0]  r_volume, n_volume;
    logic [20:0] w_inc;
    logic [20:0] w_limit;
    logic        w_flip;

    // limit is 32 times the period, zero acting as one
    assign w_limit = (i_period == 16'd0) ? 21'd32 : {i_period, 5'd0};
    assign w_inc   = r_count + 21'd1;
    assign w_flip  = r_attack ^ i_ctl.alt;

    // restart on shape write, step on tick
    always_comb begin
        n_count  = r_count;
        n_step   = r_step;
        n_attack = r_attack;
        n_volume = r_volume;
        if (i_ctl.restart) begin
            n_count  = 21'd0;
            n_step   = 5'd0;
            n_attack = i_ctl.attack_in;
            n_volume = i_ctl.attack_in ? psg_pkg::VOL_MIN : psg_pkg::VOL_MAX;
        end else if (i_ctl.tick) begin
            n_count = w_inc;
            if (w_inc >= w_limit) begin
                n_count = 21'd0;
                if (!r_step[4]) begin
                    n_volume = r_attack ? r_step[3:0] : ~r_step[3:0];
                    n_step   = r_step + 5'd1;
                end else if (!i_ctl.cont) begin
                    n_volume = psg_pkg::VOL_MIN;
                end else if (i_ctl.hold) begin
                    n_volume = w_flip ? psg_pkg::VOL_MAX : psg_pkg::VOL_MIN;
                end else begin
                    n_attack = w_flip;
                    n_step   = 5'd0;
                    n_volume = w_flip ? psg_pkg::VOL_MIN : psg_pkg::VOL_MAX;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 21'd0;
            r_step   <= 5'd0;
            r_attack <= 1'b0;
            r_volume <= 4'd0;
        end else begin
            r_count  <= n_count;
            r_step   <= n_step;
            r_attack <= n_attack;
            r_volume <= n_volume;
        end
    end

    assign o_volume_next = n_volume;

endmodule

// ===== design/psg_mix.sv =====
// ----------------------------------------------------------------------------
// psg_mix
// channel gating, volume selection and table sum
// ----------------------------------------------------------------------------
module psg_mix (
    input  logic [7:0] i_mixer,
    input  logic [7:0] i_vol_a,
    input  logic [7:0] i_vol_b,
    input  logic [7:0] i_vol_c,
    input  logic [2:0] i_tone_level,
    input  logic       i_noise_level,
    input  logic [3:0] i_env_volume,
    output logic [6:0] o_amplitude
);

    logic [7:0] w_vreg [psg_pkg::NUM_TONES];
    logic [5:0] w_part [psg_pkg::NUM_TONES];

    assign w_vreg[0] = i_vol_a;
    assign w_vreg[1] = i_vol_b;
    assign w_vreg[2] = i_vol_c;

    // per channel table volume, zero when gated off
    always_comb begin
        for (int c = 0; c < psg_pkg::NUM_TONES; c++) begin
            logic       on;
            logic [3:0] v;
            on = (i_mixer[c] | i_tone_level[c]) & (i_mixer[c + 3] | i_noise_level);
            v  = w_vreg[c][4] ? i_env_volume : w_vreg[c][3:0];
            w_part[c] = on ? psg_pkg::vol_table(v) : 6'd0;
        end
    end

    assign o_amplitude = {1'b0, w_part[0]} + {1'b0, w_part[1]} + {1'b0, w_part[2]};

endmodule

// ===== design/psg_tone_noise_envelope.sv =====
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope
// three-channel tone, noise and envelope sound generator
// ----------------------------------------------------------------------------
// Items arrive on i_in (operation, write_data) and each returns one result on
// o_out (read_data, amplitude). Operations: latch a register index, write the
// latched register, read it, or advance the generator by one tick.
// Each transfer on i_in updates all state at that clock edge and loads the
// result register; the result is valid in the cycle after.
// Throughput is one item per cycle: i_in.ready is high whenever the result
// register is empty or its result is taken in the same cycle, so the block
// keeps accepting while the receiver takes results.
// When the receiver stalls, the result holds and i_in.ready drops until the
// result is taken; nothing is lost or repeated.
// While i_rst_n is low, i_in.ready is low, the register file, index,
// counters, noise shift register and envelope return to their reset values
// and no result is pending. Ready rises as soon as reset is released.
// read_data is zero for every operation but a read; amplitude is the mixed
// table sum after the item takes effect.
// ----------------------------------------------------------------------------
`include "psg_tone_noise_envelope_assert.svh"

module psg_tone_noise_envelope (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psg_in_if.sink    i_in,
    psg_out_if.source o_out
);

    psg_pkg::t_reg_file r_regs, n_regs;
    logic [3:0]         r_index, n_index;
    logic               r_valid;
    logic [7:0]         r_read_data, n_read_data;
    logic [6:0]         r_amplitude, n_amplitude;

    logic               w_accept;
    logic               w_tick;
    logic               w_write;
    psg_pkg::t_env_ctl  w_env_ctl;
    logic [2:0]         w_tone_next;
    logic               w_noise_next;
    logic [3:0]         w_env_next;

    // handshake
    assign i_in.ready = i_rst_n && (!r_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_tick     = w_accept && (i_in.operation == psg_pkg::OP_TICK);
    assign w_write    = w_accept && (i_in.operation == psg_pkg::OP_WRITE);

    // register file, index latch and read path
    always_comb begin
        n_regs      = r_regs;
        n_index     = r_index;
        n_read_data = 8'd0;
        if (w_accept) begin
            case (i_in.operation)
                psg_pkg::OP_LATCH: n_index = i_in.write_data[3:0];
                psg_pkg::OP_WRITE: n_regs[r_index] = i_in.write_data;
                psg_pkg::OP_READ:  n_read_data = r_regs[r_index];
                default:           n_read_data = 8'd0;
            endcase
        end
    end

    // envelope control
    assign w_env_ctl.tick      = w_tick;
    assign w_env_ctl.restart   = w_write && (r_index == psg_pkg::REG_ENV_SHAPE);
    assign w_env_ctl.attack_in = i_in.write_data[2];
    assign w_env_ctl.cont      = r_regs[psg_pkg::REG_ENV_SHAPE][3];
    assign w_env_ctl.alt       = r_regs[psg_pkg::REG_ENV_SHAPE][1];
    assign w_env_ctl.hold      = r_regs[psg_pkg::REG_ENV_SHAPE][0];

    // tone channels
    for (genvar c = 0; c < psg_pkg::NUM_TONES; c++) begin : g_tone
        psg_tone u_tone (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tick       (w_tick),
            .i_period     ({r_regs[2 * c + 1][3:0], r_regs[2 * c]}),
            .o_level_next (w_tone_next[c])
        );
    end

    psg_noise u_noise (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_period     (r_regs[psg_pkg::REG_NOISE_PER][4:0]),
        .o_level_next (w_noise_next)
    );

    psg_env u_env (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_env_ctl),
        .i_period      ({r_regs[psg_pkg::REG_ENV_HI], r_regs[psg_pkg::REG_ENV_LO]}),
        .o_volume_next (w_env_next)
    );

    // amplitude from the state after this item
    psg_mix u_mix (
        .i_mixer       (n_regs[psg_pkg::REG_MIXER]),
        .i_vol_a       (n_regs[psg_pkg::REG_VOL_A]),
        .i_vol_b       (n_regs[psg_pkg::REG_VOL_A + 4'd1]),
        .i_vol_c       (n_regs[psg_pkg::REG_VOL_A + 4'd2]),
        .i_tone_level  (w_tone_next),
        .i_noise_level (w_noise_next),
        .i_env_volume  (w_env_next),
        .o_amplitude   (n_amplitude)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psg_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_index <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_regs  <= n_regs;
            r_index <= n_index;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data <= n_read_data;
            r_amplitude <= n_amplitude;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.read_data = r_read_data;
    assign o_out.amplitude = r_amplitude;

    // checks
    `PSG_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, r_valid && !o_out.ready, !i_in.ready, "input taken while result stalled")
    `PSG_ASSERT_NXT(a_accept_result, i_clk, i_rst_n, w_accept, r_valid, "transfer in without result")
    `PSG_ASSERT_NXT(a_read_zero, i_clk, i_rst_n, w_accept && (i_in.operation != psg_pkg::OP_READ), r_read_data == 8'd0, "read data nonzero for non-read")

endmodule

// ===== bench/tb_psg_tone_noise_envelope.sv =====
// ----------------------------------------------------------------------------
// tb_psg_tone_noise_envelope
// self-checking bench for the three-channel tone, noise and envelope generator
// ----------------------------------------------------------------------------
// A queue of host items (latch, write, read, tick) feeds a driver that offers
// them on i_in at the falling edge. A monitor at the rising edge runs every
// accepted item through a bit-accurate model of the generator and queues the
// result it should produce, and checks each result taken on o_out against the
// oldest one queued. A short directed sequence comes first, then random
// register programs, reads and long tick runs under three idle patterns, with
// one long receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_psg_tone_noise_envelope;

    localparam int LIMIT_CYCLES = 200000;
    localparam int ITEMS_PER_PHASE = 375;
    localparam int HOLD_CYCLES = 60;

    // envelope shape bits
    localparam int SHAPE_HOLD = 0;
    localparam int SHAPE_ALT  = 1;
    localparam int SHAPE_ATK  = 2;
    localparam int SHAPE_CONT = 3;

    typedef struct {
        psg_pkg::t_op op;
        logic [7:0]   data;
    } t_host_item;

    typedef struct {
        logic [7:0] read_data;
        logic [6:0] amplitude;
    } t_psg_result;

    logic i_clk;
    logic i_rst_n;

    psg_in_if  in_ch ();
    psg_out_if out_ch ();

    psg_tone_noise_envelope uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // generator model state
    logic [7:0]  shadow_regs [psg_pkg::NUM_REGS];
    logic [3:0]  cur_index;
    logic [11:0] tone_cnt [psg_pkg::NUM_TONES];
    logic        tone_lvl [psg_pkg::NUM_TONES];
    logic [5:0]  noise_cnt;
    logic [16:0] noise_lfsr;
    logic        noise_lvl;
    logic [20:0] env_cnt;
    logic [4:0]  env_step;
    logic        env_attack;
    logic [3:0]  env_vol;
    int          vol_levels [16] = '{0, 1, 2, 3, 4, 5, 7, 10, 13, 18, 24, 30, 36, 40, 42, 42};

    t_host_item  host_items [$];
    t_psg_result expected_outputs [$];
    t_host_item  drv_item;
    t_psg_result oldest;
    t_psg_result fresh;

    int   n_queued;
    int   n_accepted;
    int   n_checked;
    int   n_errors;
    int   n_cycles;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   idle_phase;
    logic rx_hold;
    logic in_took;

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // model: apply one item and work out the result it returns
    task automatic psg_advance(input psg_pkg::t_op op, input logic [7:0] data,
                               output logic [7:0] rd, output logic [6:0] amp);
        int         per;
        int         n;
        int         sum;
        int         c;
        logic       fb;
        logic [7:0] shape;
        logic [7:0] mix;
        logic [7:0] vr;
        logic [3:0] v;
        rd = 8'h00;
        case (op)
            psg_pkg::OP_LATCH: cur_index = data[3:0];
            psg_pkg::OP_WRITE: begin
                shadow_regs[cur_index] = data;
                // envelope restart
                if (cur_index == psg_pkg::REG_ENV_SHAPE) begin
                    env_step = '0;
                    env_cnt = '0;
                    env_attack = data[SHAPE_ATK];
                    env_vol = data[SHAPE_ATK] ? psg_pkg::VOL_MIN : psg_pkg::VOL_MAX;
                end
            end
            psg_pkg::OP_READ: rd = shadow_regs[cur_index];
            default: begin
                // tone toggles
                for (c = 0; c < psg_pkg::NUM_TONES; c++) begin
                    per = int'({shadow_regs[2 * c + 1][3:0], shadow_regs[2 * c]});
                    if (per == 0) per = 1;
                    n = int'(tone_cnt[c]) + 1;
                    if (n >= per) begin
                        n = 0;
                        tone_lvl[c] = ~tone_lvl[c];
                    end
                    tone_cnt[c] = n[11:0];
                end
                // noise shift register
                per = int'(shadow_regs[psg_pkg::REG_NOISE_PER][4:0]);
                if (per == 0) per = 1;
                n = int'(noise_cnt) + 1;
                if (n >= per * 2) begin
                    fb = noise_lfsr[0] ^ noise_lfsr[3];
                    n = 0;
                    noise_lfsr = {fb, noise_lfsr[16:1]};
                    noise_lvl = noise_lfsr[0];
                end
                noise_cnt = n[5:0];
                // envelope
                env_cnt = env_cnt + 21'd1;
                per = int'({shadow_regs[psg_pkg::REG_ENV_HI], shadow_regs[psg_pkg::REG_ENV_LO]});
                if (per == 0) per = 1;
                if (int'(env_cnt) >= per * 32) begin
                    shape = shadow_regs[psg_pkg::REG_ENV_SHAPE];
                    env_cnt = '0;
                    if (env_step < 5'd16) begin
                        env_vol = env_attack ? env_step[3:0] : psg_pkg::VOL_MAX - env_step[3:0];
                        env_step = env_step + 5'd1;
                    end else if (!shape[SHAPE_CONT]) begin
                        env_vol = psg_pkg::VOL_MIN;
                    end else if (shape[SHAPE_HOLD]) begin
                        env_vol = (env_attack ^ shape[SHAPE_ALT]) ? psg_pkg::VOL_MAX
                                                                  : psg_pkg::VOL_MIN;
                    end else begin
                        if (shape[SHAPE_ALT]) env_attack = ~env_attack;
                        env_step = '0;
                        env_vol = env_attack ? psg_pkg::VOL_MIN : psg_pkg::VOL_MAX;
                    end
                end
            end
        endcase
        // mixed table sum
        sum = 0;
        mix = shadow_regs[psg_pkg::REG_MIXER];
        for (c = 0; c < psg_pkg::NUM_TONES; c++) begin
            if ((mix[c] || tone_lvl[c]) && (mix[c + 3] || noise_lvl)) begin
                vr = shadow_regs[int'(psg_pkg::REG_VOL_A) + c];
                v = vr[4] ? env_vol : vr[3:0];
                sum += vol_levels[v];
            end
        end
        amp = sum[6:0];
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_checked, what, got, want);
        n_errors++;
    endtask

    task automatic queue_item(input psg_pkg::t_op op, input logic [7:0] data);
        t_host_item it;
        it.op = op;
        it.data = data;
        host_items.push_back(it);
        n_queued++;
    endtask

    // random register programs, reads, tick runs and stray items
    task automatic queue_random_items(input int count);
        int         start;
        int         pick;
        int         idx;
        int         run;
        logic [7:0] val;
        logic [7:0] lat;
        start = n_queued;
        while (n_queued - start < count) begin
            pick = int'($urandom_range(99));
            if (pick < 25) begin
                idx = ($urandom_range(9) == 0) ? int'(psg_pkg::REG_ENV_SHAPE)
                                               : int'($urandom_range(psg_pkg::NUM_REGS - 1));
                val = 8'($urandom_range(255));
                // keep periods short most of the time so counters wrap often
                if (idx < psg_pkg::REG_NOISE_PER) begin
                    if (idx % 2 == 0) begin
                        if ($urandom_range(3) != 0) val = 8'($urandom_range(12));
                    end else begin
                        if ($urandom_range(7) != 0) val[3:0] = 4'h0;
                    end
                end else if (idx == psg_pkg::REG_NOISE_PER) begin
                    if ($urandom_range(3) != 0) val[4:0] = 5'($urandom_range(6));
                end else if (idx == psg_pkg::REG_ENV_LO) begin
                    if ($urandom_range(3) != 0) val = 8'($urandom_range(2));
                end else if (idx == psg_pkg::REG_ENV_HI) begin
                    if ($urandom_range(19) != 0) val = 8'h00;
                end
                lat = 8'($urandom_range(255));
                lat[3:0] = idx[3:0];
                queue_item(psg_pkg::OP_LATCH, lat);
                queue_item(psg_pkg::OP_WRITE, val);
            end else if (pick < 33) begin
                lat = 8'($urandom_range(255));
                queue_item(psg_pkg::OP_LATCH, lat);
                queue_item(psg_pkg::OP_READ, 8'($urandom_range(255)));
            end else if (pick < 95) begin
                run = int'($urandom_range(40, 1));
                repeat (run) queue_item(psg_pkg::OP_TICK, 8'($urandom_range(255)));
            end else begin
                queue_item(psg_pkg::t_op'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    // item driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || in_took)) begin
            if (host_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_item = host_items.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.operation <= drv_item.op;
                in_ch.write_data <= drv_item.data;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and the long hold
    always @(negedge i_clk) begin
        out_ch.ready <= !rx_hold && ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: check taken results, then predict for the accepted item
    always @(posedge i_clk) begin
        in_took = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_outputs.size() == 0) begin
                    note_mismatch("unexpected result, amplitude", int'(out_ch.amplitude), -1);
                end else begin
                    oldest = expected_outputs.pop_front();
                    if (out_ch.read_data !== oldest.read_data)
                        note_mismatch("read_data", int'(out_ch.read_data),
                                      int'(oldest.read_data));
                    if (out_ch.amplitude !== oldest.amplitude)
                        note_mismatch("amplitude", int'(out_ch.amplitude),
                                      int'(oldest.amplitude));
                end
                n_checked++;
            end
            if (in_ch.valid && in_ch.ready) begin
                in_took = 1'b1;
                psg_advance(in_ch.operation, in_ch.write_data, fresh.read_data,
                            fresh.amplitude);
                expected_outputs.push_back(fresh);
                n_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold while the sender keeps offering
    initial begin
        rx_hold = 1'b0;
        wait (idle_phase == 2);
        repeat (30) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // stimulus and end of run
    initial begin
        int c;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = psg_pkg::OP_LATCH;
        in_ch.write_data = 8'h00;
        out_ch.ready = 1'b0;
        in_took = 1'b0;
        n_queued = 0;
        n_accepted = 0;
        n_checked = 0;
        n_errors = 0;
        n_cycles = 0;
        idle_phase = 0;
        src_idle_pct = 18;
        snk_stall_pct = 79;

        // model reset state
        for (c = 0; c < psg_pkg::NUM_REGS; c++) shadow_regs[c] = 8'h00;
        for (c = 0; c < psg_pkg::NUM_TONES; c++) begin
            tone_cnt[c] = '0;
            tone_lvl[c] = 1'b0;
        end
        cur_index = '0;
        noise_cnt = '0;
        noise_lfsr = 17'd1;
        noise_lvl = 1'b0;
        env_cnt = '0;
        env_step = '0;
        env_attack = 1'b0;
        env_vol = psg_pkg::VOL_MIN;

        // directed: read at reset, high latch bits, full bytes back, envelope
        // volume select, period lowered under a running counter, restart
        queue_item(psg_pkg::OP_READ, 8'hff);
        queue_item(psg_pkg::OP_TICK, 8'h00);
        queue_item(psg_pkg::OP_LATCH, 8'hf7);
        queue_item(psg_pkg::OP_WRITE, 8'hff);
        queue_item(psg_pkg::OP_READ, 8'h00);
        queue_item(psg_pkg::OP_LATCH, {4'h0, psg_pkg::REG_VOL_A});
        queue_item(psg_pkg::OP_WRITE, 8'h1f);
        queue_item(psg_pkg::OP_LATCH, 8'h09);
        queue_item(psg_pkg::OP_WRITE, 8'hef);
        queue_item(psg_pkg::OP_READ, 8'h5a);
        queue_item(psg_pkg::OP_LATCH, 8'h00);
        queue_item(psg_pkg::OP_WRITE, 8'h06);
        repeat (4) queue_item(psg_pkg::OP_TICK, 8'hff);
        queue_item(psg_pkg::OP_WRITE, 8'h02);
        queue_item(psg_pkg::OP_TICK, 8'h00);
        queue_item(psg_pkg::OP_LATCH, 8'h8d);
        queue_item(psg_pkg::OP_WRITE, 8'h0f);
        queue_item(psg_pkg::OP_TICK, 8'ha5);
        queue_item(psg_pkg::OP_LATCH, 8'h07);
        queue_item(psg_pkg::OP_WRITE, 8'h00);
        queue_item(psg_pkg::OP_TICK, 8'h00);
        queue_item(psg_pkg::OP_READ, 8'h00);
        queue_random_items(ITEMS_PER_PHASE);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly idle, receiver mostly ready
        wait (host_items.size() == 0);
        idle_phase = 1;
        src_idle_pct = 79;
        snk_stall_pct = 18;
        queue_random_items(ITEMS_PER_PHASE);

        // no idling on either side
        wait (host_items.size() == 0);
        idle_phase = 2;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        queue_random_items(ITEMS_PER_PHASE);

        while (!(host_items.size() == 0 && n_accepted == n_queued &&
                 expected_outputs.size() == 0))
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
